// ===== rtl/frame_mean_abs_diff_ratio_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the frame mean absolute difference ratio unit
// Shared check forms, clocked on i_clk and held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FRAME_MEAN_ABS_DIFF_RATIO_UNIT_DEFINES_SVH
`define FRAME_MEAN_ABS_DIFF_RATIO_UNIT_DEFINES_SVH

// same-cycle implication
`define FMADR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fmadr: same-cycle check failed");

// next-cycle implication
`define FMADR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fmadr: next-cycle check failed");

`endif

// ===== rtl/fmadr_pkg.sv =====
// ----------------------------------------------------------------------------
// fmadr_pkg
// Types, widths and codes shared by the frame difference ratio unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fmadr_pkg;

    localparam int MAX_DIM     = 4096;
    localparam int POS_W       = $clog2(MAX_DIM);
    localparam int DIM_W       = 13;
    localparam int STRIDE_W    = 8;
    localparam int PHASE_CNT_W = 2;
    localparam int PIX_W       = 8;
    localparam int SUM_W       = 34;
    localparam int CNT_W       = 25;
    localparam int RATIO_W     = 17;
    localparam int DIV_W       = 35;          // 765 * count
    localparam int REM_W       = DIV_W + 1;   // shifted remainder
    localparam int FULL_SCALE  = 765;         // 3 channels * 255
    localparam int RATIO_MAX   = 65536;
    localparam int QUO_BITS    = 16;
    localparam int QUO_BIT_W   = $clog2(QUO_BITS);
    localparam int CFG_IDX_W   = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_TOP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_BOTTOM  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_STRIDE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_COUNT  = 3'd6;

    typedef struct packed {
        logic [PIX_W-1:0] first_blue;
        logic [PIX_W-1:0] first_green;
        logic [PIX_W-1:0] first_red;
        logic [PIX_W-1:0] second_blue;
        logic [PIX_W-1:0] second_green;
        logic [PIX_W-1:0] second_red;
    } t_pixel;

    typedef struct packed {
        logic [RATIO_W-1:0] diff_ratio;
        logic [CNT_W-1:0]   sample_count;
    } t_result;

    typedef struct packed {
        logic [DIM_W-1:0]       frame_width;
        logic [DIM_W-1:0]       frame_height;
        logic [DIM_W-1:0]       skip_top_rows;
        logic [DIM_W-1:0]       skip_bottom_rows;
        logic [STRIDE_W-1:0]    column_stride;
        logic [STRIDE_W-1:0]    row_stride;
        logic [PHASE_CNT_W-1:0] phase_count;
    } t_cfg;

    typedef struct packed {
        logic [1:0] hits;
        logic       frame_end;
    } t_scan_status;

    typedef enum logic [1:0] {
        OP_ACC   = 2'd0,   // a + |x - z|, doubled on two hits
        OP_SCALE = 2'd1,   // b * 765
        OP_CMP   = 2'd2,   // a >= b
        OP_STEP  = 2'd3    // one restoring divide step
    } t_alu_op;

    typedef struct packed {
        t_alu_op          op;
        logic [REM_W-1:0] a;
        logic [REM_W-1:0] b;
        logic [PIX_W-1:0] x;
        logic [PIX_W-1:0] z;
        logic             dbl;
    } t_alu_req;

    typedef struct packed {
        logic [REM_W-1:0] y;
        logic             flag;
    } t_alu_rsp;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ACC   = 6'b000010,
        S_SCALE = 6'b000100,
        S_CHK   = 6'b001000,
        S_DIV   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

endpackage

// ===== rtl/frame_mean_abs_diff_ratio_unit.sv =====
// ----------------------------------------------------------------------------
// frame_mean_abs_diff_ratio_unit
// Subsampled mean absolute difference of two frames, as a Q16 ratio.
// ----------------------------------------------------------------------------
// Two frames stream in together in raster order, one pixel pair per input
// word. Rows cropped at top and bottom are skipped; within the kept rows a
// pixel is sampled on the stride grid and, with two phases set, also on the
// grid offset by half a stride. Each sample adds |dB|+|dG|+|dR| to a running
// sum; the last pixel of a frame yields one output word carrying
// floor(sum*65536/(765*count)) (0 if nothing sampled) and the sample count.
// All arithmetic goes through one shared ALU under a small sequencer: an
// unsampled pixel is only accepted, while a sampled one is accepted and then
// takes one ALU pass per colour channel. The last pixel of a frame adds a
// scale step, a compare step, one restoring divide step per quotient bit and
// a load of the output register; a frame with no samples or a saturated
// ratio skips the divide steps. The output register frees the input side once
// loaded, but a new result waits while the previous one is still untaken.
// Config writes are accepted at any time (ready tied high) and must only be
// issued while the unit is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "frame_mean_abs_diff_ratio_unit_defines.svh"

module frame_mean_abs_diff_ratio_unit import fmadr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // pixel pair words
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_pixel               i_in_data,
    // result words
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_result              o_out_data,
    // register writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data
);

    localparam logic [1:0] LAST_CHAN = 2'd2;

    // control state
    t_state               r_state, n_state;
    logic [1:0]           r_chan, n_chan;
    logic [QUO_BIT_W-1:0] r_bit, n_bit;
    logic [1:0]           r_hits, n_hits;
    logic                 r_last, n_last;
    logic [SUM_W-1:0]     r_sum, n_sum;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_out_valid, n_out_valid;
    t_cfg                 r_cfg, n_cfg;

    // payload / datapath
    t_pixel               r_in, n_in;
    logic [DIV_W-1:0]     r_div, n_div;
    logic [REM_W-1:0]     r_rem, n_rem;
    logic [RATIO_W-1:0]   r_quo, n_quo;
    t_result              r_out, n_out;

    logic                 in_acc;
    t_scan_status         scan;
    t_alu_req             alu_req;
    t_alu_rsp             alu_rsp;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    fmadr_raster u_raster (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_step   (in_acc),
        .o_status (scan)
    );

    fmadr_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    // register file
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:  n_cfg.frame_width      = i_cfg_data;
                CFG_FRAME_HEIGHT: n_cfg.frame_height     = i_cfg_data;
                CFG_SKIP_TOP:     n_cfg.skip_top_rows    = i_cfg_data;
                CFG_SKIP_BOTTOM:  n_cfg.skip_bottom_rows = i_cfg_data;
                CFG_COL_STRIDE:   n_cfg.column_stride    = i_cfg_data[STRIDE_W-1:0];
                CFG_ROW_STRIDE:   n_cfg.row_stride       = i_cfg_data[STRIDE_W-1:0];
                CFG_PHASE_COUNT:  n_cfg.phase_count      = i_cfg_data[PHASE_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_chan      = r_chan;
        n_bit       = r_bit;
        n_hits      = r_hits;
        n_last      = r_last;
        n_sum       = r_sum;
        n_cnt       = r_cnt;
        n_in        = r_in;
        n_div       = r_div;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        alu_req     = '0;
        alu_req.op  = OP_ACC;
        alu_req.a   = REM_W'(r_sum);
        alu_req.dbl = r_hits[1];
        case (r_chan)
            2'd0: begin
                alu_req.x = r_in.first_blue;
                alu_req.z = r_in.second_blue;
            end
            2'd1: begin
                alu_req.x = r_in.first_green;
                alu_req.z = r_in.second_green;
            end
            default: begin
                alu_req.x = r_in.first_red;
                alu_req.z = r_in.second_red;
            end
        endcase

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_in   = i_in_data;
                    n_hits = scan.hits;
                    n_last = scan.frame_end;
                    n_cnt  = r_cnt + CNT_W'(scan.hits);
                    if (scan.hits != 2'd0) begin
                        n_state = S_ACC;
                    end else if (scan.frame_end) begin
                        n_state = S_SCALE;
                    end
                end
            end
            S_ACC: begin
                n_sum = alu_rsp.y[SUM_W-1:0];
                if (r_chan == LAST_CHAN) begin
                    n_chan  = '0;
                    n_state = r_last ? S_SCALE : S_IDLE;
                end else begin
                    n_chan = r_chan + 1'b1;
                end
            end
            S_SCALE: begin
                alu_req.op = OP_SCALE;
                alu_req.b  = REM_W'(r_cnt);
                if (r_cnt == '0) begin
                    n_quo   = '0;
                    n_state = S_DONE;
                end else begin
                    n_div   = alu_rsp.y[DIV_W-1:0];
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                // sum >= divisor means the ratio reaches full scale
                alu_req.op = OP_CMP;
                alu_req.b  = REM_W'(r_div);
                if (alu_rsp.flag) begin
                    n_quo   = RATIO_W'(RATIO_MAX);
                    n_state = S_DONE;
                end else begin
                    n_rem   = REM_W'(r_sum);
                    n_quo   = '0;
                    n_bit   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                alu_req.op = OP_STEP;
                alu_req.a  = r_rem;
                alu_req.b  = REM_W'(r_div);
                n_rem      = alu_rsp.y;
                n_quo      = {r_quo[RATIO_W-2:0], alu_rsp.flag};
                n_bit      = r_bit + 1'b1;
                if (r_bit == QUO_BIT_W'(QUO_BITS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.diff_ratio   = r_quo;
                    n_out.sample_count = r_cnt;
                    n_out_valid        = 1'b1;
                    n_sum              = '0;
                    n_cnt              = '0;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_chan      <= '0;
            r_bit       <= '0;
            r_hits      <= '0;
            r_last      <= 1'b0;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_cfg.frame_width      <= DIM_W'(640);
            r_cfg.frame_height     <= DIM_W'(480);
            r_cfg.skip_top_rows    <= '0;
            r_cfg.skip_bottom_rows <= '0;
            r_cfg.column_stride    <= STRIDE_W'(1);
            r_cfg.row_stride       <= STRIDE_W'(1);
            r_cfg.phase_count      <= PHASE_CNT_W'(1);
        end else begin
            r_state     <= n_state;
            r_chan      <= n_chan;
            r_bit       <= n_bit;
            r_hits      <= n_hits;
            r_last      <= n_last;
            r_sum       <= n_sum;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_cfg       <= n_cfg;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in  <= n_in;
        r_div <= n_div;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_out <= n_out;
    end

    // checks
    `FMADR_ASSERT_NOW(a_rem_below_div, r_state == S_DIV, r_rem < REM_W'(r_div))
    `FMADR_ASSERT_NOW(a_ratio_bound, r_state == S_DONE, r_quo <= RATIO_W'(RATIO_MAX))
    `FMADR_ASSERT_NEXT(a_div_len, (r_state == S_DIV) && (r_bit == QUO_BIT_W'(QUO_BITS - 1)), r_state == S_DONE)
    `FMADR_ASSERT_NEXT(a_hit_to_acc, in_acc && (scan.hits != 2'd0), r_state == S_ACC)

endmodule

// ===== rtl/fmadr_alu.sv =====
// ----------------------------------------------------------------------------
// fmadr_alu
// Shared arithmetic unit: accumulate, constant scale, compare, divide step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fmadr_alu import fmadr_pkg::*; (
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic [PIX_W-1:0] absd;
    logic [REM_W-1:0] shifted;
    logic [DIV_W-1:0] prod;

    always_comb begin
        absd    = (i_req.x > i_req.z) ? (i_req.x - i_req.z) : (i_req.z - i_req.x);
        shifted = {i_req.a[REM_W-2:0], 1'b0};
        prod    = DIV_W'(i_req.b[CNT_W-1:0]) * DIV_W'(FULL_SCALE);
        o_rsp   = '0;
        unique case (i_req.op)
            OP_ACC: begin
                o_rsp.y = i_req.dbl ? (i_req.a + REM_W'({absd, 1'b0}))
                                    : (i_req.a + REM_W'(absd));
            end
            OP_SCALE: begin
                o_rsp.y = REM_W'(prod);
            end
            OP_CMP: begin
                o_rsp.flag = (i_req.a >= i_req.b);
            end
            OP_STEP: begin
                o_rsp.flag = (shifted >= i_req.b);
                o_rsp.y    = o_rsp.flag ? (shifted - i_req.b) : shifted;
            end
            default: begin
                o_rsp = '0;
            end
        endcase
    end

endmodule

// ===== rtl/fmadr_raster.sv =====
// ----------------------------------------------------------------------------
// fmadr_raster
// Raster position and stride phase tracking; flags sample hits and frame end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fmadr_raster import fmadr_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cfg         i_cfg,
    input  logic         i_step,
    output t_scan_status o_status
);

    logic [POS_W-1:0]    r_col, n_col;
    logic [POS_W-1:0]    r_row, n_row;
    logic [STRIDE_W-1:0] r_col_ph, n_col_ph;
    logic [STRIDE_W-1:0] r_row_ph, n_row_ph;

    logic [DIM_W-1:0]    w, h, y0, rows_left, bot, y1;
    logic [STRIDE_W-1:0] xs, ys, col_adv, row_adv;
    logic                two_ph, in_rows, hit_a, hit_b, row_end, frame_end;

    always_comb begin
        w = (i_cfg.frame_width == '0) ? DIM_W'(1)
          : ((i_cfg.frame_width > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : i_cfg.frame_width);
        h = (i_cfg.frame_height == '0) ? DIM_W'(1)
          : ((i_cfg.frame_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : i_cfg.frame_height);
        y0        = (i_cfg.skip_top_rows < h) ? i_cfg.skip_top_rows : h;
        rows_left = h - y0;
        bot       = (i_cfg.skip_bottom_rows < rows_left) ? i_cfg.skip_bottom_rows : rows_left;
        y1        = h - bot;

        xs = (i_cfg.column_stride == '0) ? STRIDE_W'(1) : i_cfg.column_stride;
        ys = (i_cfg.row_stride == '0) ? STRIDE_W'(1) : i_cfg.row_stride;
        // codes 2 and 3 both mean two grids
        two_ph = i_cfg.phase_count[1] && !(xs == STRIDE_W'(1) && ys == STRIDE_W'(1));

        in_rows = (DIM_W'(r_row) >= y0) && (DIM_W'(r_row) < y1);
        hit_a   = in_rows && (r_col_ph == '0) && (r_row_ph == '0);
        hit_b   = in_rows && two_ph && (r_col_ph == (xs >> 1)) && (r_row_ph == (ys >> 1));

        row_end   = (DIM_W'(r_col) + DIM_W'(1)) >= w;
        frame_end = row_end && ((DIM_W'(r_row) + DIM_W'(1)) >= h);

        col_adv = ((STRIDE_W + 1)'(r_col_ph) + 1'b1 >= (STRIDE_W + 1)'(xs))
                ? '0 : r_col_ph + 1'b1;
        row_adv = ((STRIDE_W + 1)'(r_row_ph) + 1'b1 >= (STRIDE_W + 1)'(ys))
                ? '0 : r_row_ph + 1'b1;

        o_status.hits      = {hit_a & hit_b, hit_a ^ hit_b};
        o_status.frame_end = frame_end;

        n_col    = r_col;
        n_row    = r_row;
        n_col_ph = r_col_ph;
        n_row_ph = r_row_ph;
        if (i_step) begin
            if (frame_end) begin
                n_col    = '0;
                n_row    = '0;
                n_col_ph = '0;
                n_row_ph = '0;
            end else if (row_end) begin
                n_row_ph = (DIM_W'(r_row) >= y0) ? row_adv : '0;
                n_col    = '0;
                n_col_ph = '0;
                n_row    = r_row + 1'b1;
            end else begin
                n_col    = r_col + 1'b1;
                n_col_ph = col_adv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_col_ph <= '0;
            r_row_ph <= '0;
        end else begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_col_ph <= n_col_ph;
            r_row_ph <= n_row_ph;
        end
    end

endmodule

// ===== dv/frame_mean_abs_diff_ratio_unit_tb.sv =====
// ----------------------------------------------------------------------------
// frame_mean_abs_diff_ratio_unit_tb
// Self-checking bench for the frame mean absolute difference ratio unit.
// A short table of directed pixel words and register writes runs first. Its
// obvious results (saturation, zero difference, cropped-out frames) are typed
// in. Random frames follow under many register settings, wide and tall
// extremes among them, and a few settings are changed mid-frame. Every result
// word is checked against the typed value or else a predictor kept in step
// with each accepted pixel. Both handshakes see random gaps, and the
// receiver holds off once for a long stretch so that the unit backs up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frame_mean_abs_diff_ratio_unit_tb;
    import fmadr_pkg::*;

    localparam int          ITEMS_TARGET  = 1000;
    localparam int          SETTLE_CYCLES = 32;       // last sampled pixel or a frame end
    localparam int          HOLD_CYCLES   = 400;      // long receiver hold-off
    localparam int unsigned CYCLE_LIMIT   = 3_000_000;
    localparam int          N_ROWS        = 40;
    localparam int          EXTREME_ITEMS = 256;      // words sent into a widest/tallest frame

    // index with no register behind it, written once to show it is ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    // ------------------------------------------------------------------------
    // DUT ports, every input driven to a known value from time zero
    // ------------------------------------------------------------------------
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    t_pixel               i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_result              o_out_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [DIM_W-1:0]     i_cfg_data  = '0;

    frame_mean_abs_diff_ratio_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Predictor: register copies and scan state, reset values as after reset
    // ------------------------------------------------------------------------
    logic [DIM_W-1:0]       reg_width   = 13'd640;
    logic [DIM_W-1:0]       reg_height  = 13'd480;
    logic [DIM_W-1:0]       reg_top     = '0;
    logic [DIM_W-1:0]       reg_bottom  = '0;
    logic [STRIDE_W-1:0]    reg_cstride = 8'd1;
    logic [STRIDE_W-1:0]    reg_rstride = 8'd1;
    logic [PHASE_CNT_W-1:0] reg_phases  = 2'd1;

    int unsigned       col_pos   = 0;
    int unsigned       row_pos   = 0;
    int unsigned       col_phase = 0;
    int unsigned       row_phase = 0;
    logic [SUM_W-1:0]  diff_sum      = '0;
    logic [CNT_W-1:0]  sampled_total = '0;

    // results owed by the unit, oldest first
    t_result pending_ratios[$];

    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned quiet_left     = 0;   // sender words still to go with no gap
    bit          hold_req       = 1'b0;
    bit          hold_taken     = 1'b0;

    // zero acts as one, anything past MAX_DIM as MAX_DIM
    function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return v;
    endfunction

    function automatic int unsigned chan_diff(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Advance the scan by one pixel pair; returns 1 with the result word when
    // this pixel closes the frame.
    function automatic bit predict_frame_mean(input t_pixel px, output t_result res);
        int unsigned w, h, y0, bot, y1, xs, ys, nph, hits, d;
        bit          row_end, frame_end;
        logic [63:0] ratio;
        w   = clamp_dim(reg_width);
        h   = clamp_dim(reg_height);
        y0  = (reg_top < h) ? reg_top : h;
        bot = (reg_bottom < h - y0) ? reg_bottom : h - y0;
        y1  = h - bot;
        xs  = (reg_cstride == 0) ? 1 : reg_cstride;
        ys  = (reg_rstride == 0) ? 1 : reg_rstride;
        nph = (reg_phases == 0) ? 1 : ((reg_phases > 2) ? 2 : reg_phases);
        // unit strides leave no room for an offset grid
        if (xs == 1 && ys == 1) nph = 1;
        res  = '0;
        hits = 0;
        if (row_pos >= y0 && row_pos < y1) begin
            if (col_phase == 0 && row_phase == 0) hits++;
            if (nph == 2 && col_phase == xs / 2 && row_phase == ys / 2) hits++;
        end
        if (hits != 0) begin
            d = chan_diff(px.first_blue, px.second_blue)
              + chan_diff(px.first_green, px.second_green)
              + chan_diff(px.first_red, px.second_red);
            diff_sum      = diff_sum + SUM_W'(d * hits);
            sampled_total = sampled_total + CNT_W'(hits);
        end
        row_end   = (col_pos + 1 >= w);
        frame_end = row_end && (row_pos + 1 >= h);
        if (frame_end) begin
            ratio = '0;
            if (sampled_total != 0) begin
                ratio = ({30'd0, diff_sum} << QUO_BITS)
                      / (64'(FULL_SCALE) * 64'(sampled_total));
                if (ratio > RATIO_MAX) ratio = RATIO_MAX;
            end
            res.diff_ratio   = ratio[RATIO_W-1:0];
            res.sample_count = sampled_total;
            col_pos       = 0;
            row_pos       = 0;
            col_phase     = 0;
            row_phase     = 0;
            diff_sum      = '0;
            sampled_total = '0;
            return 1'b1;
        end
        if (row_end) begin
            // rows above the crop keep the row phase parked at zero
            if (row_pos >= y0) row_phase = (row_phase + 1 >= ys) ? 0 : row_phase + 1;
            else               row_phase = 0;
            col_pos   = 0;
            col_phase = 0;
            row_pos++;
        end else begin
            col_pos++;
            col_phase = (col_phase + 1 >= xs) ? 0 : col_phase + 1;
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------------
    // Directed table: register writes and pixel words. Pixel constants read
    // first B G R | second B G R. Typed results are the obvious ones only.
    // ------------------------------------------------------------------------
    typedef enum logic { ROW_REG, ROW_PIX } t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [DIM_W-1:0]     val;
        t_pixel               pix;
        logic                 typed;
        t_result              res;
    } t_dir_row;

    t_dir_row directed_plan [N_ROWS] = '{
        '{ROW_REG, CFG_UNUSED,       13'h1FFF, 48'h0, 1'b0, '0},
        // single-pixel frames: every word closes a frame
        '{ROW_REG, CFG_FRAME_WIDTH,  13'd1, 48'h0, 1'b0, '0},
        '{ROW_REG, CFG_FRAME_HEIGHT, 13'd1, 48'h0, 1'b0, '0},
        '{ROW_PIX, CFG_UNUSED, 13'd0, 48'hFFFFFF_000000, 1'b1, '{17'h10000, 25'd1}},
        '{ROW_PIX, CFG_UNUSED, 13'd0, 48'h000000_FFFFFF, 1'b1, '{17'h10000, 25'd1}},
        '{ROW_PIX, CFG_UNUSED, 13'd0, 48'h5A5A5A_5A5A5A, 1'b1, '{17'd0, 25'd1}},
        '{ROW_PIX, CFG_UNUSED, 13'd0, 48'h010000_000000, 1'b0, '0},
        '{ROW_PIX, CFG_UNUSED, 13'd0, 48'h80C040_7FC140, 1'b0, '0},
        // top crop covering the whole frame: nothing sampled
        '{ROW_REG, CFG_SKIP_TOP,     13'd1, 48'h0, 1'b0, '0},
        '{ROW_PIX, CFG_UNUSED, 13'd0, 48'hA53C96_3CA569, 1'b1, '{17'd0, 25'd0}},
        '{ROW_REG, CFG_SKIP_TOP,     13'h1FFF, 48'h0, 1'b0, '0},
        '{ROW_PIX, CFG_UNUSED, 13'd0, 48'hFFFFFF_000000, 1'b1, '{17'd0, 25'd0}},
        // bottom crop past the frame, clamped to the rows left
        '{ROW_REG, CFG_SKIP_TOP,     13'd0, 48'h0, 1'b0, '0},
        '{ROW_REG, CFG_SKIP_BOTTOM,  13'h1FFF, 48'h0, 1'b0, '0},
        '{ROW_PIX, CFG_UNUSED, 13'd0, 48'hFFFFFF_000000, 1'b1, '{17'd0, 25'd0}},
        // zero dimensions act as one
        '{ROW_REG, CFG_SKIP_BOTTOM,  13'd0, 48'h0, 1'b0, '0},
        '{ROW_REG, CFG_FRAME_WIDTH,  13'd0, 48'h0, 1'b0, '0},
        '{ROW_REG, CFG_FRAME_HEIGHT, 13'd0, 48'h0, 1'b0, '0},
        '{ROW_PIX, CFG_UNUSED, 13'd0, 48'h00FF00_FF00FF, 1'b1, '{17'h10000, 25'd1}},
        // 2x2 frame, stride two, phase count three acting as two
        '{ROW_REG, CFG_FRAME_WIDTH,  13'd2, 48'h0, 1'b0, '0},
        '{ROW_REG, CFG_FRAME_HEIGHT, 13'd2, 48'h0, 1'b0, '0},
        '{ROW_REG, CFG_COL_STRIDE,   13'd2, 48'h0, 1'b0, '0},
        '{ROW_REG, CFG_ROW_STRIDE,   13'd2, 48'h0, 1'b0, '0},
        '{ROW_REG, CFG_PHASE_COUNT,  13'd3, 48'h0, 1'b0, '0},
        '{ROW_PIX, CFG_UNUSED, 13'd0, 48'h102030_302010, 1'b0, '0},
        '{ROW_PIX, CFG_UNUSED, 13'd0, 48'hFFFFFF_000000, 1'b0, '0},
        '{ROW_PIX, CFG_UNUSED, 13'd0, 48'h000000_FFFFFF, 1'b0, '0},
        '{ROW_PIX, CFG_UNUSED, 13'd0, 48'h123456_654321, 1'b0, '0},
        // both strides one (zero row stride): single grid despite two phases
        '{ROW_REG, CFG_COL_STRIDE,   13'd1, 48'h0, 1'b0, '0},
        '{ROW_REG, CFG_ROW_STRIDE,   13'd0, 48'h0, 1'b0, '0},
        '{ROW_PIX, CFG_UNUSED, 13'd0, 48'hFFFFFF_000000, 1'b0, '0},
        '{ROW_PIX, CFG_UNUSED, 13'd0, 48'hFFFFFF_000000, 1'b0, '0},
        '{ROW_PIX, CFG_UNUSED, 13'd0, 48'hFFFFFF_000000, 1'b0, '0},
        '{ROW_PIX, CFG_UNUSED, 13'd0, 48'hFFFFFF_000000, 1'b1, '{17'h10000, 25'd4}},
        // phase count zero acts as one; widest column stride
        '{ROW_REG, CFG_PHASE_COUNT,  13'd0, 48'h0, 1'b0, '0},
        '{ROW_REG, CFG_COL_STRIDE,   13'd255, 48'h0, 1'b0, '0},
        '{ROW_PIX, CFG_UNUSED, 13'd0, 48'h00FF00_000000, 1'b0, '0},
        '{ROW_PIX, CFG_UNUSED, 13'd0, 48'h111111_111111, 1'b0, '0},
        '{ROW_PIX, CFG_UNUSED, 13'd0, 48'h000000_FFFFFF, 1'b0, '0},
        '{ROW_PIX, CFG_UNUSED, 13'd0, 48'h7F7F7F_807F80, 1'b0, '0}
    };

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Offer one pixel word after a random gap; valid stays high across
    // back-to-back words. On acceptance the predictor steps and any result
    // is queued (the typed value where the table gives one).
    task automatic send_pixel(input t_pixel px, input bit typed, input t_result typed_res);
        int unsigned gap, r;
        t_result     res;
        r = $urandom_range(0, 99);
        if (quiet_left > 0) begin
            quiet_left--;
            gap = 0;
        end else if (r < 5) begin
            quiet_left = $urandom_range(30, 150);
            gap = 0;
        end else if (r < 55) gap = 0;
        else if (r < 85)     gap = $urandom_range(1, 3);
        else if (r < 97)     gap = $urandom_range(4, 10);
        else                 gap = $urandom_range(20, 60);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= px;
        do @(posedge i_clk); while (!o_in_ready);
        if (predict_frame_mean(px, res)) pending_ratios.push_back(typed ? typed_res : res);
    endtask

    // Drop valid, let every owed result drain, then give the unit time to
    // finish a sampled pixel that owes nothing.
    task automatic quiesce();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_ratios.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register write; the predictor copy follows on acceptance.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_FRAME_WIDTH:  reg_width   = val;
            CFG_FRAME_HEIGHT: reg_height  = val;
            CFG_SKIP_TOP:     reg_top     = val;
            CFG_SKIP_BOTTOM:  reg_bottom  = val;
            CFG_COL_STRIDE:   reg_cstride = val[STRIDE_W-1:0];
            CFG_ROW_STRIDE:   reg_rstride = val[STRIDE_W-1:0];
            CFG_PHASE_COUNT:  reg_phases  = val[PHASE_CNT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Receiver side: ready runs and stalls of random length, plus one long
    // hold-off on request so the output register fills and input backs up
    // ------------------------------------------------------------------------
    initial begin
        int unsigned run, stall, r;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            r   = $urandom_range(0, 99);
            run = (r < 15) ? $urandom_range(50, 200) : $urandom_range(1, 12);
            repeat (run) begin
                @(negedge i_clk);
                if (hold_req && !hold_taken) break;
            end
            r = $urandom_range(0, 99);
            if (r < 40)      stall = 0;
            else if (r < 92) stall = $urandom_range(1, 4);
            else             stall = $urandom_range(20, 60);
            if (stall > 0 && !(hold_req && !hold_taken)) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Checking: each accepted result word against the oldest owed result
    // ------------------------------------------------------------------------
    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("[%0t] %s", $time, msg);
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_ratios.size() == 0) begin
                note_mismatch($sformatf("result word with none owed: diff_ratio %0d sample_count %0d",
                                        o_out_data.diff_ratio, o_out_data.sample_count));
            end else begin
                want = pending_ratios.pop_front();
                if (o_out_data.diff_ratio !== want.diff_ratio)
                    note_mismatch($sformatf("diff_ratio: expected %0d, got %0d",
                                            want.diff_ratio, o_out_data.diff_ratio));
                if (o_out_data.sample_count !== want.sample_count)
                    note_mismatch($sformatf("sample_count: expected %0d, got %0d",
                                            want.sample_count, o_out_data.sample_count));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        t_cfg        setting;
        t_pixel      px;
        int unsigned phase_no, random_items, n_items, frame_px, r;
        phase_no     = 0;
        random_items = 0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (directed_plan[i]) begin
            if (directed_plan[i].kind == ROW_REG) begin
                quiesce();
                write_reg(directed_plan[i].idx, directed_plan[i].val);
            end else begin
                send_pixel(directed_plan[i].pix, directed_plan[i].typed, directed_plan[i].res);
            end
        end

        // Random phases. Phase 0 is single-pixel frames under the long
        // hold-off; phases 3 and 6 open one widest and one tallest frame and
        // leave it part way. A phase may stop mid-frame, so the next setting
        // lands mid-frame.
        while (phase_no <= 6 || random_items < ITEMS_TARGET) begin
            case (phase_no)
                0: begin
                    setting = '{13'd1, 13'd1, 13'd0, 13'd0, 8'd1, 8'd1, 2'd1};
                    n_items = 120;
                end
                3: begin
                    setting = '{13'h1FFF, 13'd1, 13'd0, 13'd0, 8'd255,
                                8'($urandom), 2'd2};
                    n_items = EXTREME_ITEMS;
                end
                6: begin
                    setting = '{13'd1, 13'h1FFF, 13'($urandom_range(0, 10)),
                                13'($urandom_range(0, 10)), 8'd0, 8'd255, 2'd2};
                    n_items = EXTREME_ITEMS;
                end
                default: begin
                    setting.frame_width      = 13'($urandom_range(0, 12));
                    setting.frame_height     = 13'($urandom_range(0, 8));
                    setting.skip_top_rows    = ($urandom_range(0, 9) == 0) ?
                                               13'h1FFF : 13'($urandom_range(0, 3));
                    setting.skip_bottom_rows = ($urandom_range(0, 9) == 0) ?
                                               13'h1FFF : 13'($urandom_range(0, 3));
                    setting.column_stride    = ($urandom_range(0, 3) == 0) ?
                                               8'($urandom) : 8'($urandom_range(0, 4));
                    setting.row_stride       = ($urandom_range(0, 3) == 0) ?
                                               8'($urandom) : 8'($urandom_range(0, 4));
                    setting.phase_count      = 2'($urandom_range(0, 3));
                    frame_px = clamp_dim(setting.frame_width) * clamp_dim(setting.frame_height);
                    if ($urandom_range(0, 3) == 0) n_items = $urandom_range(1, 2 * frame_px);
                    else                           n_items = frame_px * $urandom_range(1, 3);
                end
            endcase

            quiesce();
            write_reg(CFG_FRAME_WIDTH,  setting.frame_width);
            write_reg(CFG_FRAME_HEIGHT, setting.frame_height);
            write_reg(CFG_SKIP_TOP,     setting.skip_top_rows);
            write_reg(CFG_SKIP_BOTTOM,  setting.skip_bottom_rows);
            // junk above the field width must be dropped
            write_reg(CFG_COL_STRIDE,   {5'($urandom), setting.column_stride});
            write_reg(CFG_ROW_STRIDE,   {5'($urandom), setting.row_stride});
            write_reg(CFG_PHASE_COUNT,  {11'($urandom), setting.phase_count});
            if (phase_no == 0) hold_req = 1'b1;

            for (int k = 0; k < n_items; k++) begin
                {px.first_blue, px.first_green, px.first_red, px.second_blue} = $urandom;
                {px.second_green, px.second_red} = 16'($urandom);
                r = $urandom_range(0, 9);
                // full-scale and zero differences now and then
                if (r == 0)
                    {px.second_blue, px.second_green, px.second_red} =
                        ~{px.first_blue, px.first_green, px.first_red};
                else if (r == 1)
                    {px.second_blue, px.second_green, px.second_red} =
                        {px.first_blue, px.first_green, px.first_red};
                send_pixel(px, 1'b0, '0);
                random_items++;
            end
            phase_no++;
        end

        quiesce();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
